>>> rtl/brst_pkg.sv
package brst_pkg;

    localparam int BR_DEPTH = 16;
    localparam int FR_DEPTH = 32;
    localparam int BR_AW    = (BR_DEPTH > 1) ? $clog2(BR_DEPTH) : 1;
    localparam int FR_AW    = (FR_DEPTH > 1) ? $clog2(FR_DEPTH) : 1;
    localparam int BC_W     = $clog2(BR_DEPTH + 1);
    localparam int FC_W     = $clog2(FR_DEPTH + 1);

    localparam logic [1:0] FUNC_EXEC   = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;

    typedef enum logic [1:0] {
        XFER_SEQ  = 2'd0,
        XFER_JUMP = 2'd1,
        XFER_CALL = 2'd2
    } t_xfer;

    typedef enum logic [1:0] {
        REC_HDR    = 2'd0,
        REC_FRAME  = 2'd1,
        REC_BRANCH = 2'd2,
        REC_OVF    = 2'd3
    } t_rec;

    typedef struct packed {
        logic       latch;
        logic       start;
        logic       stop;
        logic       fptr_load;
        logic       pop_rd;
        logic       fptr_dec;
        logic       fcnt_pop;
        logic       walk_init;
        logic       frd_walk;
        logic       wi_dec;
        logic       brd;
        logic       bi_dec;
        logic       bclr;
        logic       commit;
        logic       emit;
        t_rec       emit_kind;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic       running;
        logic       bcnt_nz;
        logic       bcnt_full;
        logic       fcnt_nz;
        logic       fptr_one;
        logic       fptr_full;
        logic       pop_hit;
        logic       wi_one;
        logic       bi_one;
        logic       out_free;
        t_xfer      kind;
    } t_sts;

    // decode the previous instruction at p given the current address c
    function automatic t_xfer classify(logic [63:0] p, logic [63:0] c,
                                       logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        logic [7:0] op;
        logic [7:0] modrm;
        logic [2:0] rg;
        t_xfer      k;
        op    = b0;
        modrm = b1;
        k     = XFER_SEQ;
        if (b0 >= 8'h40 && b0 <= 8'h4f) begin
            op    = b1;
            modrm = b2;
        end
        rg = modrm[5:3];
        if (p == 64'd0) begin
            k = XFER_SEQ;
        end else if (b0 >= 8'h70 && b0 <= 8'h7f) begin
            k = (c != p + 64'd2) ? XFER_JUMP : XFER_SEQ;
        end else if (b0 == 8'h0f && b1 >= 8'h80 && b1 <= 8'h8f) begin
            k = (c != p + 64'd6) ? XFER_JUMP : XFER_SEQ;
        end else if (b0 >= 8'he0 && b0 <= 8'he3) begin
            k = (c != p + 64'd2) ? XFER_JUMP : XFER_SEQ;
        end else if (b0 == 8'he8) begin
            k = XFER_CALL;
        end else if (b0 == 8'he9 || b0 == 8'heb || b0 == 8'hc2 || b0 == 8'hc3) begin
            k = XFER_JUMP;
        end else if (op == 8'hff) begin
            if (rg == 3'd2 || rg == 3'd3) k = XFER_CALL;
            else if (rg == 3'd4 || rg == 3'd5) k = XFER_JUMP;
        end
        return k;
    endfunction

endpackage

>>> rtl/brst_ram.sv
module brst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/brst_dp.sv
module brst_dp import brst_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic [215:0]  i_in_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [127:0]  o_data,
    output logic [1:0]    o_user,
    output logic          o_last
);

    logic [63:0]      r_ip, r_sp, r_top, r_last_ip;
    logic [7:0]       r_b0, r_b1, r_b2;
    logic             r_running;
    logic [BC_W-1:0]  r_bcnt, r_bi;
    logic [FC_W-1:0]  r_fcnt, r_fptr, r_wi;
    logic             r_valid, r_last;
    logic [1:0]       r_user;
    logic [127:0]     r_data;

    logic [FC_W-1:0]  n_fptr_m1, n_wi_m1;
    logic [BC_W-1:0]  n_bi_m1;
    logic [127:0]     fr_rdata, br_rdata;
    logic             fr_we, br_we, fr_re;
    logic [FR_AW-1:0] fr_raddr;
    t_xfer            kind;

    assign kind      = classify(r_last_ip, r_ip, r_b0, r_b1, r_b2);
    assign n_fptr_m1 = r_fptr - FC_W'(1);
    assign n_wi_m1   = r_wi - FC_W'(1);
    assign n_bi_m1   = r_bi - BC_W'(1);

    assign fr_we    = i_cmd.commit && kind == XFER_CALL;
    assign br_we    = i_cmd.commit && kind != XFER_SEQ;
    assign fr_re    = i_cmd.pop_rd || i_cmd.frd_walk;
    assign fr_raddr = i_cmd.pop_rd ? n_fptr_m1[FR_AW-1:0] : n_wi_m1[FR_AW-1:0];

    // frame word: {return address, stack pointer}
    brst_ram #(.WIDTH(128), .DEPTH(FR_DEPTH)) u_fram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_fptr[FR_AW-1:0]),
        .i_wdata ({r_top, r_sp}),
        .i_re    (fr_re),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    // branch word: {target, source}
    brst_ram #(.WIDTH(128), .DEPTH(BR_DEPTH)) u_bram (
        .i_clk   (i_clk),
        .i_we    (br_we),
        .i_waddr (r_bcnt[BR_AW-1:0]),
        .i_wdata ({r_ip, r_last_ip}),
        .i_re    (i_cmd.brd),
        .i_raddr (n_bi_m1[BR_AW-1:0]),
        .o_rdata (br_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_ip  <= i_in_data[63:0];
            r_sp  <= i_in_data[127:64];
            r_top <= i_in_data[191:128];
            r_b0  <= i_in_data[199:192];
            r_b1  <= i_in_data[207:200];
            r_b2  <= i_in_data[215:208];
        end
        if (i_cmd.fptr_load) r_fptr <= r_fcnt;
        else if (i_cmd.fptr_dec) r_fptr <= n_fptr_m1;
        if (i_cmd.walk_init) begin
            r_wi <= r_fcnt;
            r_bi <= r_bcnt;
        end else begin
            if (i_cmd.wi_dec) r_wi <= n_wi_m1;
            if (i_cmd.bi_dec) r_bi <= n_bi_m1;
        end
        if (i_cmd.emit) begin
            r_user <= i_cmd.emit_kind;
            r_last <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                REC_HDR:    r_data <= {64'd0, r_last_ip};
                REC_FRAME:  r_data <= {64'd0, fr_rdata[127:64]};
                REC_BRANCH: r_data <= br_rdata;
                default:    r_data <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_last_ip <= '0;
            r_bcnt    <= '0;
            r_fcnt    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_running <= 1'b1;
                r_last_ip <= '0;
                r_bcnt    <= '0;
                r_fcnt    <= '0;
            end
            if (i_cmd.stop) r_running <= 1'b0;
            if (i_cmd.bclr) r_bcnt <= '0;
            if (i_cmd.fcnt_pop) r_fcnt <= r_fptr;
            if (i_cmd.commit) begin
                r_fcnt    <= (kind == XFER_CALL) ? r_fptr + FC_W'(1) : r_fptr;
                if (kind != XFER_SEQ) r_bcnt <= r_bcnt + BC_W'(1);
                r_last_ip <= r_ip;
            end
            if (i_cmd.emit) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.running   = r_running;
        o_sts.bcnt_nz   = r_bcnt != '0;
        o_sts.bcnt_full = r_bcnt >= BC_W'(BR_DEPTH);
        o_sts.fcnt_nz   = r_fcnt != '0;
        o_sts.fptr_one  = r_fptr == FC_W'(1);
        o_sts.fptr_full = r_fptr >= FC_W'(FR_DEPTH);
        o_sts.pop_hit   = fr_rdata[63:0] < r_sp;
        o_sts.wi_one    = r_wi == FC_W'(1);
        o_sts.bi_one    = r_bi == BC_W'(1);
        o_sts.out_free  = !r_valid || i_ready;
        o_sts.kind      = kind;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

>>> rtl/brst_ctrl.sv
module brst_ctrl import brst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLS, S_POP_RD, S_POP_CMP, S_POP_DONE, S_HDR,
        S_FRD, S_FOUT, S_BRD, S_BOUT, S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;
    logic   ovf;

    assign ovf        = i_sts.kind == XFER_CALL && i_sts.fptr_full;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_fin   = r_fin;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func)
                        FUNC_START: o_cmd.start = 1'b1;
                        FUNC_FINISH: begin
                            o_cmd.stop = 1'b1;
                            if (i_sts.running && i_sts.bcnt_nz) begin
                                n_fin   = 1'b1;
                                n_state = S_HDR;
                            end
                        end
                        FUNC_EXEC: begin
                            if (i_sts.running) begin
                                o_cmd.latch = 1'b1;
                                n_state     = S_CLS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLS: begin
                o_cmd.fptr_load = 1'b1;
                n_state = i_sts.fcnt_nz ? S_POP_RD : S_POP_DONE;
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_CMP;
            end
            S_POP_CMP: begin
                if (i_sts.pop_hit) begin
                    o_cmd.fptr_dec = 1'b1;
                    n_state = i_sts.fptr_one ? S_POP_DONE : S_POP_RD;
                end else begin
                    n_state = S_POP_DONE;
                end
            end
            S_POP_DONE: begin
                n_fin = 1'b0;
                if (i_sts.kind != XFER_SEQ && i_sts.bcnt_full) n_state = S_HDR;
                else n_state = S_COMMIT;
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = REC_HDR;
                    o_cmd.walk_init = 1'b1;
                    n_state = i_sts.fcnt_nz ? S_FRD : S_BRD;
                end
            end
            S_FRD: begin
                o_cmd.frd_walk = 1'b1;
                n_state        = S_FOUT;
            end
            S_FOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = REC_FRAME;
                    o_cmd.wi_dec    = 1'b1;
                    n_state = i_sts.wi_one ? S_BRD : S_FRD;
                end
            end
            S_BRD: begin
                o_cmd.brd = 1'b1;
                n_state   = S_BOUT;
            end
            S_BOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = REC_BRANCH;
                    // an overflow record, if any, closes the run instead
                    o_cmd.emit_last = i_sts.bi_one && (r_fin || !ovf);
                    o_cmd.bi_dec    = 1'b1;
                    if (i_sts.bi_one) begin
                        o_cmd.bclr = 1'b1;
                        n_state = r_fin ? S_IDLE : S_COMMIT;
                    end else begin
                        n_state = S_BRD;
                    end
                end
            end
            S_COMMIT: begin
                if (ovf) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = REC_OVF;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.fcnt_pop  = 1'b1;
                        o_cmd.stop      = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

>>> rtl/branch_record_shadow_stack_tracer.sv
// Branch record tracer with a shadow call stack.
// Input stream: one beat per retired instruction. tuser = func (exec, finish,
// start); tdata carries the instruction address, stack pointer, stack top word
// and the first three bytes of the previous instruction.
// Output stream: one beat per record; tuser = record kind, tlast closes the
// records caused by one input beat.
// Sequencing: start, finish with nothing to flush, and exec beats while not
// running are handled in the idle state. A traced exec beat latches the
// input, checks the shadow stack with a registered read of the frame RAM and
// a compare per frame in the pop loop, then commits. A sample emits the
// header, then per frame and per branch one RAM read then one beat.
// One item is in work at a time; tready is high only while idle.
// A finished record sits in the output register, so a new input beat can be
// taken while it waits. A stalled receiver holds the walk at the next beat.
// Reset clears the counters and the running flag; RAM contents are read only
// below the counts and need no clearing.
module branch_record_shadow_stack_tracer import brst_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instr_addr, stack_ptr, stack_top_word, prev_byte0, prev_byte1, prev_byte2
    input  logic [215:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // addr_a, addr_b
    output logic [127:0] m_axis_tdata,
    // record_kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    brst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brst_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_in_data (s_axis_tdata),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

>>> rtl/brst_chk.sv
module brst_chk import brst_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == REC_OVF |-> m_axis_tlast)
        else $error("overflow record not last");

    a_hdr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == REC_HDR || m_axis_tuser == REC_FRAME)
        |-> !m_axis_tlast)
        else $error("sample cut short");

    a_hdr_zero_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != REC_BRANCH |-> m_axis_tdata[127:64] == 64'd0)
        else $error("addr_b nonzero on non-branch record");

endmodule

bind branch_record_shadow_stack_tracer brst_chk u_brst_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
